FILE: hw/rtl/urfc_pkg.sv
// Shared types and constants for the ultrasonic range frame checker.
package urfc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RangeW = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_DIST = 2'd0,
    CFG_MAX_DIST = 2'd1,
    CFG_HEADER   = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_CHECKSUM  = 2'd1,
    STAT_ABOVE_MAX = 2'd2,
    STAT_BELOW_MIN = 2'd3
  } frame_status_e;

  localparam logic [RangeW-1:0] MinDistRst = 16'd30;
  localparam logic [RangeW-1:0] MaxDistRst = 16'd4500;
  localparam logic [ByteW-1:0]  HeaderRst  = 8'hff;

  typedef struct packed {
    logic [RangeW-1:0] min_distance;
    logic [RangeW-1:0] max_distance;
    logic [ByteW-1:0]  header_value;
  } cfg_t;

endpackage

FILE: hw/rtl/ultrasonic_range_frame_checker_core.sv
// Ultrasonic range frame checker: parses header/high/low/checksum frames from a byte stream.
// Takes one byte per cycle unless a waiting result holds the stream; a byte is registered in the input register and
// a completed frame's result appears in the output register in the cycle after
// the checksum word is accepted, unless an earlier result still waits there.
// Only a checksum word waits on a full result register; other words keep flowing.
// Bytes before a header are dropped, and each frame yields one result word with the
// clamped distance (or the last good distance on a checksum error) and a status code.
// Configuration writes take effect on the next cycle.
module ultrasonic_range_frame_checker_core
  import urfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RangeW-1:0]  cfg_wdata_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,  // [7:0] rx_byte
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [15:0]        m_axis_tdata_o,  // [15:0] range_value
  output logic [1:0]         m_axis_tuser_o   // [1:0] frame_status
);

  cfg_t             cfg;
  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             pop;

  urfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  urfc_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_byte_i  (s_axis_tdata_i),
    .valid_o   (in_valid),
    .byte_o    (in_byte),
    .pop_i     (pop)
  );

  urfc_frame_parser u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid),
    .in_byte_i      (in_byte),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .range_value_o  (m_axis_tdata_o),
    .frame_status_o (m_axis_tuser_o)
  );

endmodule

FILE: hw/rtl/urfc_cfg_regs.sv
// Configuration register file: distance limits and header byte.
module urfc_cfg_regs
  import urfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RangeW-1:0]  cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_DIST: cfg_d.min_distance = cfg_wdata_i;
        CFG_MAX_DIST: cfg_d.max_distance = cfg_wdata_i;
        CFG_HEADER:   cfg_d.header_value = cfg_wdata_i[ByteW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_distance <= MinDistRst;
      cfg_q.max_distance <= MaxDistRst;
      cfg_q.header_value <= HeaderRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/urfc_in_stage.sv
// Input register for received bytes.
module urfc_in_stage
  import urfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [ByteW-1:0] s_byte_i,
  output logic             valid_o,
  output logic [ByteW-1:0] byte_o,
  input  logic             pop_i
);

  logic             valid_q;
  logic [ByteW-1:0] byte_q;

  assign s_ready_o = !valid_q || pop_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      byte_q <= s_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

FILE: hw/rtl/urfc_frame_parser.sv
// Frame state, checksum and limit check, and the result register.
module urfc_frame_parser
  import urfc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  input  logic [ByteW-1:0]  in_byte_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [RangeW-1:0] range_value_o,
  output logic [1:0]        frame_status_o
);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_CHECK = 2'd3
  } phase_e;

  phase_e            phase_d, phase_q;
  logic [ByteW-1:0]  high_q, low_q;
  logic [RangeW-1:0] last_q;
  logic              out_valid_q;
  logic [RangeW-1:0] range_q;
  frame_status_e     status_q;

  logic              out_free;
  logic              is_check;
  logic [ByteW-1:0]  sum;
  logic [RangeW-1:0] dist_raw;
  logic [RangeW-1:0] dist_sel;
  frame_status_e     status;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_check = (phase_q == PH_CHECK);
  // Bytes that give no result move on even while a result waits.
  assign pop_o    = in_valid_i && (!is_check || out_free);

  assign sum      = cfg_i.header_value + high_q + low_q;
  assign dist_raw = {high_q, low_q};

  always_comb begin
    if (sum != in_byte_i) begin
      status   = STAT_CHECKSUM;
      dist_sel = last_q;
    end else if (dist_raw > cfg_i.max_distance) begin
      status   = STAT_ABOVE_MAX;
      dist_sel = cfg_i.max_distance;
    end else if (dist_raw < cfg_i.min_distance) begin
      status   = STAT_BELOW_MIN;
      dist_sel = cfg_i.min_distance;
    end else begin
      status   = STAT_OK;
      dist_sel = dist_raw;
    end
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_HUNT:  if (in_byte_i == cfg_i.header_value) phase_d = PH_HIGH;
      PH_HIGH:  phase_d = PH_LOW;
      PH_LOW:   phase_d = PH_CHECK;
      PH_CHECK: phase_d = PH_HUNT;
      default:  phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      high_q      <= '0;
      low_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && is_check) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        phase_q <= phase_d;
        if (phase_q == PH_HIGH) begin
          high_q <= in_byte_i;
        end
        if (phase_q == PH_LOW) begin
          low_q <= in_byte_i;
        end
        if (is_check && (status != STAT_CHECKSUM)) begin
          last_q <= dist_sel;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_check) begin
      range_q  <= dist_sel;
      status_q <= status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign range_value_o  = range_q;
  assign frame_status_o = status_q;

endmodule

FILE: tb/tb_ultrasonic_range_frame_checker_core.sv
// Testbench for the ultrasonic range frame checker core: byte stream in, checked readings out.
`timescale 1ns / 100ps

module tb_ultrasonic_range_frame_checker_core;
  import urfc_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [RangeW-1:0] range_value;
    frame_status_e     frame_status;
  } reading_t;

  // Tracks the frame parser state and holds the readings still owed by the block.
  class range_scoreboard;
    logic [RangeW-1:0] min_dist;
    logic [RangeW-1:0] max_dist;
    logic [ByteW-1:0]  hdr;
    logic [1:0]        phase;
    logic [ByteW-1:0]  hi_byte;
    logic [ByteW-1:0]  lo_byte;
    logic [RangeW-1:0] last_good;
    reading_t          expected_readings[$];
    int unsigned       mismatches;

    function new();
      min_dist   = MinDistRst;
      max_dist   = MaxDistRst;
      hdr        = HeaderRst;
      phase      = 2'd0;
      hi_byte    = '0;
      lo_byte    = '0;
      last_good  = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [RangeW-1:0] val);
      case (idx)
        CFG_MIN_DIST: min_dist = val;
        CFG_MAX_DIST: max_dist = val;
        CFG_HEADER:   hdr = val[ByteW-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [ByteW-1:0] b);
      logic [ByteW-1:0]  sum;
      logic [RangeW-1:0] dist_v;
      reading_t          rd;
      case (phase)
        2'd0: if (b == hdr) phase = 2'd1;
        2'd1: begin
          hi_byte = b;
          phase = 2'd2;
        end
        2'd2: begin
          lo_byte = b;
          phase = 2'd3;
        end
        default: begin
          phase = 2'd0;
          sum = hdr + hi_byte + lo_byte;
          if (sum != b) begin
            rd.range_value  = last_good;
            rd.frame_status = STAT_CHECKSUM;
          end else begin
            dist_v = {hi_byte, lo_byte};
            rd.frame_status = STAT_OK;
            // max check wins when the limits cross
            if (dist_v > max_dist) begin
              dist_v = max_dist;
              rd.frame_status = STAT_ABOVE_MAX;
            end else if (dist_v < min_dist) begin
              dist_v = min_dist;
              rd.frame_status = STAT_BELOW_MIN;
            end
            last_good = dist_v;
            rd.range_value = dist_v;
          end
          expected_readings.push_back(rd);
        end
      endcase
    endfunction

    function void check_reading(logic [RangeW-1:0] range_v, logic [1:0] status_v);
      reading_t rd;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected reading range=%0d status=%0d", range_v, status_v);
      end else begin
        rd = expected_readings.pop_front();
        if (rd.range_value !== range_v || rd.frame_status !== status_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: reading mismatch: expected range=%0d status=%0d, got range=%0d status=%0d",
                     rd.range_value, rd.frame_status, range_v, status_v);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RangeW-1:0]  cfg_wdata_i = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i = '0;   // [7:0] rx_byte
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [15:0]        m_axis_tdata_o;        // [15:0] range_value
  logic [1:0]         m_axis_tuser_o;        // [1:0] frame_status

  range_scoreboard sb = new();
  bit              calm = 1'b0;
  int unsigned     words_sent = 0;
  int unsigned     cycles = 0;

  ultrasonic_range_frame_checker_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("ultrasonic_range_frame_checker_core test failed");
      $finish;
    end
  end

  // Result side: check accepted words, stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_reading(m_axis_tdata_o, m_axis_tuser_o);
      m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.take_byte(b);
    words_sent++;
  endtask

  task automatic send_frame(input logic [15:0] range_in, input bit good_sum);
    logic [7:0] chk;
    chk = sb.hdr + range_in[15:8] + range_in[7:0];
    if (!good_sum) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(sb.hdr);
    send_byte(range_in[15:8]);
    send_byte(range_in[7:0]);
    send_byte(chk);
  endtask

  // Sender holds off until every owed reading is in, then lets the pipe settle.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [15:0] min_v, input logic [15:0] max_v,
                            input logic [7:0] hdr_v);
    cfg_idx_e    idx;
    logic [15:0] val;
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: begin
          idx = CFG_MIN_DIST;
          val = min_v;
        end
        1: begin
          idx = CFG_MAX_DIST;
          val = max_v;
        end
        default: begin
          idx = CFG_HEADER;
          val = {8'h00, hdr_v};
        end
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= val;
      @(posedge clk_i);
      sb.set_reg(idx, val);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Distances cluster around the limits and the ends of the range.
  function automatic logic [15:0] pick_distance();
    int d;
    case ($urandom_range(0, 5))
      0: d = int'(sb.min_dist) + $urandom_range(0, 6) - 3;
      1: d = int'(sb.max_dist) + $urandom_range(0, 6) - 3;
      2: d = $urandom_range(0, 255);
      3: d = $urandom_range(65280, 65535);
      default: d = $urandom_range(0, 65535);
    endcase
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return 16'(d);
  endfunction

  task automatic random_traffic(input int unsigned n_words);
    int unsigned stop_at;
    int unsigned r;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_frame(pick_distance(), $urandom_range(0, 9) != 0);
      end else if (r < 88) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        // cut-off frame: the following bytes get parsed as its data
        send_byte(sb.hdr);
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset limits 30..4500, header 0xff
    send_byte(8'h00);
    send_byte(8'h80);
    send_frame(16'd1000, 1'b1);
    send_frame(16'hffff, 1'b1);   // high byte equals the header
    send_frame(16'd0, 1'b1);
    send_frame(16'd4500, 1'b1);
    send_frame(16'd30, 1'b1);
    send_frame(16'd1234, 1'b0);
    drain_results();

    write_regs(16'd0, 16'hffff, 8'h00);
    random_traffic(250);
    drain_results();

    // long stretch without stalls on either side
    write_regs(16'd1000, 16'd2000, 8'h55);
    calm = 1'b1;
    random_traffic(300);
    drain_results();
    calm = 1'b0;

    // crossed limits
    write_regs(16'hffff, 16'd0, 8'ha5);
    random_traffic(200);
    drain_results();

    // header register changes in the middle of a frame
    send_byte(8'ha5);
    send_byte(8'h12);
    drain_results();
    write_regs(16'd500, 16'd60000, 8'hff);
    send_byte(8'h34);
    send_byte(8'(8'hff + 8'h12 + 8'h34));
    random_traffic(250);
    drain_results();

    for (int p = 0; p < 3; p++) begin
      write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 8'($urandom_range(0, 255)));
      random_traffic(210);
      drain_results();
    end

    write_regs(16'd1234, 16'd1234, 8'h12);
    random_traffic(200);
    drain_results();

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ultrasonic_range_frame_checker_core test passed");
    end else begin
      $display("ultrasonic_range_frame_checker_core test failed");
    end
    $finish;
  end

endmodule
